>>> src/i2csbc_pkg.sv
// Shared constants, types and response decode for the I2C slave byte controller.
package i2csbc_pkg;

	// Store sizes
	localparam int TX_DEPTH = 16;
	localparam int RX_DEPTH = 32;

	// Field widths
	localparam int CMD_W      = 3;
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 4;
	localparam int LEN_W      = 5;
	localparam int ADDR_W     = 7;
	localparam int BITS_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Derived widths: transmit address, transmit pointer (0..TX_DEPTH),
	// receive address and count (0..RX_DEPTH-1), remainder step counter
	localparam int TX_AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int TX_PW  = $clog2(TX_DEPTH + 1);
	localparam int RX_AW  = $clog2(RX_DEPTH);
	localparam int STEP_W = $clog2(IDX_W);
	localparam int DEN_W  = LEN_W + IDX_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SHIFT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TX_WRITE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TX_INDEX = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TX_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd2;

	// Constant bytes and transfer lengths
	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;
	localparam logic [BITS_W-1:0] BITS_ACK  = 4'd1;
	localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;

	// Reset values of configuration
	localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 7'd0;
	localparam logic [LEN_W-1:0]  TX_LENGTH_RST   = 5'd16;

	// Line response selector
	typedef enum logic [2:0] {
		RSP_START      = 3'd0,
		RSP_RELEASE    = 3'd1,
		RSP_NO_MATCH   = 3'd2,
		RSP_ACK_DRIVE  = 3'd3,
		RSP_ACK_LISTEN = 3'd4,
		RSP_RX_WAIT    = 3'd5,
		RSP_TX_DATA    = 3'd6
	} rsp_t;

	// Line response fields
	typedef struct packed {
		logic              load_shift;
		logic [BYTE_W-1:0] shift_value;
		logic [BITS_W-1:0] bits_next;
		logic              sda_drive;
		logic              go_idle;
	} line_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept_en;
		logic tx_write;
		logic mod_start;
		logic mod_step;
		logic tx_send;
		logic rx_store;
		logic emit_line;
		rsp_t rsp_sel;
		logic dump_start;
		logic dump_read;
		logic dump_emit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic             taken;
		logic [CMD_W-1:0] cmd;
		logic             aborted;
		logic             enabled;
		logic             addr_match;
		logic             nack;
		logic             dir_read;
		logic             count_zero;
		logic             mod_last;
		logic             dump_last;
		logic             out_free;
		logic             enable_written;
	} dp_stat_t;

	// Decode a line response into its fields
	function automatic line_t line_fields(rsp_t sel, logic [BYTE_W-1:0] tx_data);
		line_t l;
		l.load_shift  = 1'b0;
		l.shift_value = BYTE_ZERO;
		l.bits_next   = BITS_BYTE;
		l.sda_drive   = 1'b0;
		l.go_idle     = 1'b0;
		unique case (sel)
			RSP_START: begin
				l.load_shift  = 1'b1;
				l.shift_value = BYTE_ONES;
			end
			RSP_RELEASE: begin
				l.go_idle = 1'b1;
			end
			RSP_NO_MATCH: begin
				l.load_shift = 1'b1;
				l.go_idle    = 1'b1;
			end
			RSP_ACK_DRIVE: begin
				l.load_shift = 1'b1;
				l.bits_next  = BITS_ACK;
				l.sda_drive  = 1'b1;
			end
			RSP_ACK_LISTEN: begin
				l.load_shift = 1'b1;
				l.bits_next  = BITS_ACK;
			end
			RSP_RX_WAIT: begin
				l.bits_next = BITS_BYTE;
			end
			RSP_TX_DATA: begin
				l.load_shift  = 1'b1;
				l.shift_value = tx_data;
				l.sda_drive   = 1'b1;
			end
			default: begin
				l.go_idle = 1'b0;
			end
		endcase
		return l;
	endfunction

endpackage

>>> src/i2csbc_ifs.sv
// Valid/ready channel interfaces: bus events in, responses out, configuration writes.
interface i2csbc_evt_if;
	import i2csbc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] shift_byte;
	logic              start_aborted;
	logic [IDX_W-1:0]  entry_index;
	logic [BYTE_W-1:0] entry_value;
	modport source(output valid, cmd, shift_byte, start_aborted, entry_index, entry_value,
		input ready);
	modport sink(input valid, cmd, shift_byte, start_aborted, entry_index, entry_value,
		output ready);
endinterface

interface i2csbc_rsp_if;
	import i2csbc_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic              load_shift;
	logic [BYTE_W-1:0] shift_value;
	logic [BITS_W-1:0] bits_next;
	logic              sda_drive;
	logic              go_idle;
	logic [BYTE_W-1:0] rx_byte;
	logic              last;
	modport source(output valid, kind, load_shift, shift_value, bits_next, sda_drive, go_idle,
		rx_byte, last, input ready);
	modport sink(input valid, kind, load_shift, shift_value, bits_next, sda_drive, go_idle,
		rx_byte, last, output ready);
endinterface

interface i2csbc_cfg_if;
	import i2csbc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> src/i2csbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2csbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/i2csbc_dp.sv
// Datapath: word capture, configuration, transmit pointer, stores and response register.
module i2csbc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	i2csbc_evt_if.sink            bus_evt,
	i2csbc_cfg_if.sink            cfg,
	i2csbc_rsp_if.source          resp,
	input  i2csbc_pkg::ctrl_cmd_t cmd,
	output i2csbc_pkg::dp_stat_t  st
);
	import i2csbc_pkg::*;

	// Captured input word
	logic [CMD_W-1:0]  cmd_q;
	logic [BYTE_W-1:0] byte_q;
	logic              aborted_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] val_q;

	// Configuration
	logic [ADDR_W-1:0] own_addr_q;
	logic [LEN_W-1:0]  tx_len_q;
	logic              enabled_q;

	// Transmit pointer and remainder unit
	logic [TX_PW-1:0]  tx_ptr_q;
	logic [TX_PW-1:0]  ptr_wrap;
	logic [LEN_W-1:0]  eff_len;
	logic [IDX_W-1:0]  rem_q;
	logic [IDX_W-1:0]  rem_next;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  den;

	// Receive store bookkeeping
	logic [RX_AW-1:0]  rx_count_q;
	logic [RX_AW-1:0]  dump_k_q;
	logic              rx_full;
	logic              dump_last;

	// Store ports
	logic              tx_wr_en;
	logic [BYTE_W-1:0] tx_rdata;
	logic              rx_wr_en;
	logic [BYTE_W-1:0] rx_rdata;

	// Response register
	logic              out_valid_q;
	logic              out_kind_q;
	line_t             out_line_q;
	logic [BYTE_W-1:0] out_rx_q;
	logic              out_last_q;
	logic              out_free;
	line_t             line_next;
	logic              take;
	logic              cfg_wr;

	assign bus_evt.ready = cmd.accept_en;
	assign take          = bus_evt.valid & bus_evt.ready;
	assign cfg.ready     = 1'b1;
	assign cfg_wr        = cfg.valid & cfg.ready;

	// Capture the accepted word
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q     <= bus_evt.cmd;
			byte_q    <= bus_evt.shift_byte;
			aborted_q <= bus_evt.start_aborted;
			idx_q     <= bus_evt.entry_index;
			val_q     <= bus_evt.entry_value;
		end
	end

	// Configuration registers; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= OWN_ADDRESS_RST;
			tx_len_q   <= TX_LENGTH_RST;
			enabled_q  <= 1'b1;
		end else if (cfg_wr) begin
			if (cfg.index == CFG_OWN_ADDRESS) begin
				own_addr_q <= cfg.data[ADDR_W-1:0];
			end
			if (cfg.index == CFG_TX_LENGTH) begin
				tx_len_q <= cfg.data[LEN_W-1:0];
			end
			if (cfg.index == CFG_ENABLED) begin
				enabled_q <= cfg.data[0];
			end
		end
	end

	// Effective length: zero counts as one, clipped to the store depth
	always_comb begin
		eff_len = tx_len_q;
		if (tx_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(tx_len_q) > TX_DEPTH) begin
			eff_len = LEN_W'(TX_DEPTH);
		end
	end

	assign ptr_wrap = (32'(tx_ptr_q) >= 32'(eff_len)) ? '0 : tx_ptr_q;

	// Restoring remainder step: subtract eff_len << step when it fits
	assign den      = DEN_W'(eff_len) << step_q;
	assign rem_next = (DEN_W'(rem_q) >= den) ? (rem_q - den[IDX_W-1:0]) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			rem_q  <= idx_q;
			step_q <= STEP_W'(IDX_W - 1);
		end else if (cmd.mod_step) begin
			rem_q  <= rem_next;
			step_q <= step_q - 1'b1;
		end
	end

	// Transmit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_ptr_q <= '0;
		end else if (cmd.tx_send) begin
			tx_ptr_q <= ptr_wrap + 1'b1;
		end else if (cmd.mod_step && step_q == '0) begin
			tx_ptr_q <= TX_PW'(rem_next);
		end
	end

	// Transmit store
	assign tx_wr_en = cmd.tx_write && (32'(idx_q) < TX_DEPTH);

	i2csbc_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_wr_en),
		.wr_addr (TX_AW'(idx_q)),
		.wr_data (val_q),
		.rd_en   (cmd.tx_send),
		.rd_addr (TX_AW'(ptr_wrap)),
		.rd_data (tx_rdata)
	);

	// Receive store: bytes past RX_DEPTH-1 are dropped
	assign rx_full   = (rx_count_q == RX_AW'(RX_DEPTH - 1));
	assign rx_wr_en  = cmd.rx_store && !rx_full;
	assign dump_last = (dump_k_q == rx_count_q - 1'b1);

	i2csbc_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_wr_en),
		.wr_addr (rx_count_q),
		.wr_data (byte_q),
		.rd_en   (cmd.dump_read),
		.rd_addr (dump_k_q),
		.rd_data (rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
		end else if (rx_wr_en) begin
			rx_count_q <= rx_count_q + 1'b1;
		end else if (cmd.dump_emit && dump_last) begin
			rx_count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_start) begin
			dump_k_q <= '0;
		end else if (cmd.dump_emit) begin
			dump_k_q <= dump_k_q + 1'b1;
		end
	end

	// Response register
	assign out_free  = !out_valid_q || resp.ready;
	assign line_next = line_fields(cmd.rsp_sel, tx_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_line || cmd.dump_emit) begin
			out_valid_q <= 1'b1;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_line) begin
			out_kind_q <= 1'b0;
			out_line_q <= line_next;
			out_rx_q   <= BYTE_ZERO;
			out_last_q <= 1'b1;
		end else if (cmd.dump_emit) begin
			out_kind_q <= 1'b1;
			out_line_q <= line_fields(RSP_RX_WAIT, BYTE_ZERO);
			out_rx_q   <= rx_rdata;
			out_last_q <= dump_last;
		end
	end

	assign resp.valid       = out_valid_q;
	assign resp.kind        = out_kind_q;
	assign resp.load_shift  = out_line_q.load_shift;
	assign resp.shift_value = out_line_q.shift_value;
	assign resp.bits_next   = out_line_q.bits_next;
	assign resp.sda_drive   = out_line_q.sda_drive;
	assign resp.go_idle     = out_line_q.go_idle;
	assign resp.rx_byte     = out_rx_q;
	assign resp.last        = out_last_q;

	// Status to the controller
	assign st.taken          = take;
	assign st.cmd            = cmd_q;
	assign st.aborted        = aborted_q;
	assign st.enabled        = enabled_q;
	assign st.addr_match     = (byte_q[BYTE_W-1:1] == own_addr_q);
	assign st.nack           = (byte_q != BYTE_ZERO);
	assign st.dir_read       = byte_q[0];
	assign st.count_zero     = (rx_count_q == '0);
	assign st.mod_last       = (step_q == '0);
	assign st.dump_last      = dump_last;
	assign st.out_free       = out_free;
	assign st.enable_written = cfg_wr && (cfg.index == CFG_ENABLED);

`ifndef SYNTHESIS
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tx_ptr_q) <= TX_DEPTH)
		else $error("transmit pointer beyond store depth");
	a_rx_word_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q) |-> (!out_line_q.load_shift && !out_line_q.sda_drive
		&& !out_line_q.go_idle && out_line_q.bits_next == BITS_BYTE))
		else $error("received byte word carries line fields");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_line || cmd.dump_emit) |-> out_free)
		else $error("response register overwritten before it was taken");
`endif

endmodule

>>> src/i2csbc_ctrl.sv
// Controller: byte phase, transaction state and the sequencing of each word.
module i2csbc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2csbc_pkg::dp_stat_t  st,
	output i2csbc_pkg::ctrl_cmd_t cmd
);
	import i2csbc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECODE  = 6'b000010,
		S_MOD     = 6'b000100,
		S_EMIT    = 6'b001000,
		S_DUMP_RD = 6'b010000,
		S_DUMP_WR = 6'b100000
	} state_t;

	typedef enum logic [5:0] {
		PH_CHECK_ADDR = 6'b000001,
		PH_SEND_DATA  = 6'b000010,
		PH_REQ_ACK    = 6'b000100,
		PH_CHECK_ACK  = 6'b001000,
		PH_RECV_DATA  = 6'b010000,
		PH_STORE_ACK  = 6'b100000
	} phase_t;

	typedef enum logic [4:0] {
		TS_BEFORE_START = 5'b00001,
		TS_AFTER_START  = 5'b00010,
		TS_SELECTED     = 5'b00100,
		TS_NOT_SELECTED = 5'b01000,
		TS_DATA         = 5'b10000
	} tstate_t;

	state_t  state_q, state_d;
	phase_t  phase_q, phase_d;
	tstate_t tstate_q, tstate_d;
	logic    armed_q, armed_d;
	rsp_t    rsp_q, rsp_d;
	logic    do_send;

	// Next-state and command decode
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		tstate_d = tstate_q;
		armed_d  = armed_q;
		rsp_d    = rsp_q;
		do_send  = 1'b0;
		cmd      = '0;
		cmd.rsp_sel = rsp_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept_en = 1'b1;
				if (st.taken) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				priority if (st.cmd == CMD_TX_WRITE) begin
					cmd.tx_write = 1'b1;
				end else if (st.cmd == CMD_TX_INDEX) begin
					cmd.mod_start = 1'b1;
					state_d       = S_MOD;
				end else if (!st.enabled) begin
					state_d = S_IDLE;
				end else if (st.cmd == CMD_START) begin
					state_d = S_EMIT;
					if (st.aborted) begin
						armed_d = 1'b0;
						rsp_d   = RSP_RELEASE;
					end else begin
						phase_d  = PH_CHECK_ADDR;
						tstate_d = TS_AFTER_START;
						armed_d  = 1'b1;
						rsp_d    = RSP_START;
					end
				end else if (st.cmd == CMD_SHIFT && armed_q) begin
					state_d = S_EMIT;
					unique case (phase_q)
						PH_SEND_DATA: begin
							do_send = 1'b1;
						end
						PH_REQ_ACK: begin
							phase_d = PH_CHECK_ACK;
							rsp_d   = RSP_ACK_LISTEN;
						end
						PH_CHECK_ACK: begin
							if (st.nack) begin
								phase_d = PH_CHECK_ADDR;
								armed_d = 1'b0;
								rsp_d   = RSP_RELEASE;
							end else begin
								do_send = 1'b1;
							end
						end
						PH_RECV_DATA: begin
							tstate_d = TS_DATA;
							phase_d  = PH_STORE_ACK;
							rsp_d    = RSP_RX_WAIT;
						end
						PH_STORE_ACK: begin
							phase_d      = PH_RECV_DATA;
							cmd.rx_store = 1'b1;
							rsp_d        = RSP_ACK_DRIVE;
						end
						default: begin
							// address byte
							if (st.addr_match) begin
								tstate_d = TS_SELECTED;
								phase_d  = st.dir_read ? PH_SEND_DATA : PH_RECV_DATA;
								rsp_d    = RSP_ACK_DRIVE;
							end else begin
								tstate_d = TS_NOT_SELECTED;
								armed_d  = 1'b0;
								rsp_d    = RSP_NO_MATCH;
							end
						end
					endcase
					// next transmit byte is read from the store here
					if (do_send) begin
						tstate_d    = TS_DATA;
						phase_d     = PH_REQ_ACK;
						rsp_d       = RSP_TX_DATA;
						cmd.tx_send = 1'b1;
					end
				end else if (st.cmd == CMD_STOP) begin
					tstate_d = TS_BEFORE_START;
					if (tstate_q == TS_AFTER_START) begin
						armed_d = 1'b0;
						rsp_d   = RSP_RELEASE;
						state_d = S_EMIT;
					end else if (tstate_q == TS_DATA && !st.count_zero) begin
						cmd.dump_start = 1'b1;
						state_d        = S_DUMP_RD;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_last) begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_line = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				cmd.dump_read = 1'b1;
				state_d       = S_DUMP_WR;
			end
			S_DUMP_WR: begin
				if (st.out_free) begin
					cmd.dump_emit = 1'b1;
					state_d       = st.dump_last ? S_IDLE : S_DUMP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers; any write to enabled disarms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_CHECK_ADDR;
			tstate_q <= TS_BEFORE_START;
			armed_q  <= 1'b0;
			rsp_q    <= RSP_RELEASE;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			tstate_q <= tstate_d;
			armed_q  <= armed_d && !st.enable_written;
			rsp_q    <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	a_armed_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> st.enabled)
		else $error("armed while disabled");
	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP_RD) |-> !st.count_zero)
		else $error("receive dump with empty store");
	a_tx_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && rsp_q == RSP_TX_DATA) |-> (tstate_q == TS_DATA))
		else $error("transmit byte outside data state");
`endif

endmodule

>>> src/i2c_slave_byte_controller_top.sv
// I2C slave byte controller: bus event in, line responses and received bytes out.
//
// Channels: bus_evt carries one bus or store event per word (start, shift
// done, stop, transmit store write, transmit index set); resp returns the
// words each event causes; cfg writes own_address (0), tx_length (1) and
// enabled (2). Words move when valid and ready are both high.
// Sequencing: a start or shift-done event is decoded, then its response is
// loaded into the response register once that register is free.
// A store write is done in decode; an index set runs a four-step remainder by the
// effective transmit length. A stop after received data emits one word per
// stored byte, each by a receive RAM read, then a register load, with
// the final one marked last.
// The event channel is ready again once the last response is registered,
// so one event may be taken while that response still waits.
// Reset: phases return to address check / before start, the transmit pointer
// and receive count clear, configuration returns to address 0, length 16,
// enabled. Store contents are not cleared.
// Stall: a held response blocks the controller; no word is lost or repeated.
module i2c_slave_byte_controller_top (
	input  logic         clk,
	input  logic         arst_n,
	i2csbc_evt_if.sink   bus_evt,
	i2csbc_cfg_if.sink   cfg,
	i2csbc_rsp_if.source resp
);
	import i2csbc_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	i2csbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (dp_stat),
		.cmd    (ctrl_cmd)
	);

	i2csbc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.bus_evt (bus_evt),
		.cfg     (cfg),
		.resp    (resp),
		.cmd     (ctrl_cmd),
		.st      (dp_stat)
	);

endmodule

>>> tb/i2c_slave_byte_controller_top_checker.sv
// Response checker for the I2C slave byte controller: predicts every response word and compares.
`timescale 1ns / 100ps

module i2c_slave_byte_controller_top_checker
	import i2csbc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	i2csbc_evt_if  bus_evt,
	i2csbc_cfg_if  cfg,
	i2csbc_rsp_if  resp,
	output int     fail_count,
	output int     pending,
	output int     checked
);

	typedef enum logic [2:0] {
		PH_CHECK_ADDR,
		PH_SEND_DATA,
		PH_REQUEST_ACK,
		PH_CHECK_ACK,
		PH_RECEIVE,
		PH_STORE_ACK
	} byte_phase_t;

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_STARTED,
		TS_SELECTED,
		TS_NOT_SELECTED,
		TS_DATA
	} txn_state_t;

	typedef struct packed {
		logic              kind;
		logic              load_shift;
		logic [BYTE_W-1:0] shift_value;
		logic [BITS_W-1:0] bits_next;
		logic              sda_drive;
		logic              go_idle;
		logic [BYTE_W-1:0] rx_byte;
		logic              last;
	} resp_word_t;

	// words the block owes, oldest first
	resp_word_t resp_expected[$];

	// configuration copy
	logic [ADDR_W-1:0] own_addr;
	logic [LEN_W-1:0]  tx_len;
	logic              bus_enabled;

	// sequencer copy
	byte_phase_t       byte_phase;
	txn_state_t        txn_state;
	int unsigned       tx_ptr;
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
	logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
	int unsigned       rx_cnt;
	logic              armed;

	// transmit window actually in use
	function automatic int unsigned tx_span();
		int unsigned n;
		n = tx_len;
		if (n == 0) n = 1;
		if (n > TX_DEPTH) n = TX_DEPTH;
		return n;
	endfunction

	task automatic push_line(input logic load, input logic [BYTE_W-1:0] value,
		input logic [BITS_W-1:0] bits, input logic drive, input logic idle);
		resp_word_t w;
		w.kind        = 1'b0;
		w.load_shift  = load;
		w.shift_value = value;
		w.bits_next   = bits;
		w.sda_drive   = drive;
		w.go_idle     = idle;
		w.rx_byte     = BYTE_ZERO;
		w.last        = 1'b1;
		resp_expected.push_back(w);
	endtask

	task automatic release_line();
		armed = 1'b0;
		push_line(1'b0, BYTE_ZERO, BITS_BYTE, 1'b0, 1'b1);
	endtask

	// next transmit byte, wrapping at the window
	task automatic send_tx_byte();
		logic [BYTE_W-1:0] v;
		txn_state  = TS_DATA;
		byte_phase = PH_REQUEST_ACK;
		if (tx_ptr >= tx_span()) tx_ptr = 0;
		v = tx_mem[tx_ptr];
		tx_ptr++;
		push_line(1'b1, v, BITS_BYTE, 1'b1, 1'b0);
	endtask

	task automatic take_shift(input logic [BYTE_W-1:0] b);
		case (byte_phase)
			PH_SEND_DATA: begin
				send_tx_byte();
			end
			PH_REQUEST_ACK: begin
				byte_phase = PH_CHECK_ACK;
				push_line(1'b1, BYTE_ZERO, BITS_ACK, 1'b0, 1'b0);
			end
			PH_CHECK_ACK: begin
				// master NACK ends the read
				if (b != BYTE_ZERO) begin
					byte_phase = PH_CHECK_ADDR;
					release_line();
				end else begin
					send_tx_byte();
				end
			end
			PH_RECEIVE: begin
				txn_state  = TS_DATA;
				byte_phase = PH_STORE_ACK;
				push_line(1'b0, BYTE_ZERO, BITS_BYTE, 1'b0, 1'b0);
			end
			PH_STORE_ACK: begin
				// full store: ack anyway, drop the byte
				byte_phase = PH_RECEIVE;
				if (rx_cnt < RX_DEPTH - 1) begin
					rx_mem[rx_cnt] = b;
					rx_cnt++;
				end
				push_line(1'b1, BYTE_ZERO, BITS_ACK, 1'b1, 1'b0);
			end
			default: begin
				if (b[BYTE_W-1:1] == own_addr) begin
					txn_state  = TS_SELECTED;
					byte_phase = b[0] ? PH_SEND_DATA : PH_RECEIVE;
					push_line(1'b1, BYTE_ZERO, BITS_ACK, 1'b1, 1'b0);
				end else begin
					txn_state = TS_NOT_SELECTED;
					armed     = 1'b0;
					push_line(1'b1, BYTE_ZERO, BITS_BYTE, 1'b0, 1'b1);
				end
			end
		endcase
	endtask

	// stop: release after a bare start, or deliver the kept bytes after data
	task automatic take_stop();
		resp_word_t w;
		if (txn_state == TS_STARTED) begin
			release_line();
		end else if (txn_state == TS_DATA && rx_cnt != 0) begin
			for (int unsigned k = 0; k < rx_cnt; k++) begin
				w.kind        = 1'b1;
				w.load_shift  = 1'b0;
				w.shift_value = BYTE_ZERO;
				w.bits_next   = BITS_BYTE;
				w.sda_drive   = 1'b0;
				w.go_idle     = 1'b0;
				w.rx_byte     = rx_mem[k];
				w.last        = (k + 1 == rx_cnt);
				resp_expected.push_back(w);
			end
			rx_cnt = 0;
		end
		txn_state = TS_IDLE;
	endtask

	task automatic predict_event();
		case (bus_evt.cmd)
			CMD_START: begin
				if (bus_enabled) begin
					if (bus_evt.start_aborted) begin
						release_line();
					end else begin
						byte_phase = PH_CHECK_ADDR;
						txn_state  = TS_STARTED;
						armed      = 1'b1;
						push_line(1'b1, BYTE_ONES, BITS_BYTE, 1'b0, 1'b0);
					end
				end
			end
			CMD_SHIFT: begin
				if (bus_enabled && armed) take_shift(bus_evt.shift_byte);
			end
			CMD_STOP: begin
				if (bus_enabled) take_stop();
			end
			CMD_TX_WRITE: begin
				tx_mem[bus_evt.entry_index] = bus_evt.entry_value;
			end
			CMD_TX_INDEX: begin
				tx_ptr = bus_evt.entry_index % tx_span();
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		if (fail_count < 40) $display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// compare the accepted word with the oldest one owed
	task automatic check_word();
		resp_word_t want;
		if (resp_expected.size() == 0) begin
			report_mismatch("response word with nothing expected");
			return;
		end
		want = resp_expected.pop_front();
		checked++;
		if (resp.kind !== want.kind)
			report_mismatch($sformatf("word %0d kind: want %0d got %0d",
				checked, want.kind, resp.kind));
		if (resp.load_shift !== want.load_shift)
			report_mismatch($sformatf("word %0d load_shift: want %0d got %0d",
				checked, want.load_shift, resp.load_shift));
		if (resp.shift_value !== want.shift_value)
			report_mismatch($sformatf("word %0d shift_value: want %02h got %02h",
				checked, want.shift_value, resp.shift_value));
		if (resp.bits_next !== want.bits_next)
			report_mismatch($sformatf("word %0d bits_next: want %0d got %0d",
				checked, want.bits_next, resp.bits_next));
		if (resp.sda_drive !== want.sda_drive)
			report_mismatch($sformatf("word %0d sda_drive: want %0d got %0d",
				checked, want.sda_drive, resp.sda_drive));
		if (resp.go_idle !== want.go_idle)
			report_mismatch($sformatf("word %0d go_idle: want %0d got %0d",
				checked, want.go_idle, resp.go_idle));
		if (resp.rx_byte !== want.rx_byte)
			report_mismatch($sformatf("word %0d rx_byte: want %02h got %02h",
				checked, want.rx_byte, resp.rx_byte));
		if (resp.last !== want.last)
			report_mismatch($sformatf("word %0d last: want %0d got %0d",
				checked, want.last, resp.last));
	endtask

	// responses first, then register writes, then new events
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr    = OWN_ADDRESS_RST;
			tx_len      = TX_LENGTH_RST;
			bus_enabled = 1'b1;
			byte_phase  = PH_CHECK_ADDR;
			txn_state   = TS_IDLE;
			tx_ptr      = 0;
			rx_cnt      = 0;
			armed       = 1'b0;
			fail_count  = 0;
			checked     = 0;
			resp_expected.delete();
			pending <= 0;
		end else begin
			if (resp.valid && resp.ready) check_word();
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_OWN_ADDRESS: own_addr = cfg.data[ADDR_W-1:0];
					CFG_TX_LENGTH:   tx_len = cfg.data[LEN_W-1:0];
					CFG_ENABLED: begin
						bus_enabled = cfg.data[0];
						armed       = 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (bus_evt.valid && bus_evt.ready) predict_event();
			pending <= resp_expected.size();
		end
	end

endmodule

>>> tb/i2c_slave_byte_controller_top_tb.sv
// Testbench top for the I2C slave byte controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module i2c_slave_byte_controller_top_tb;
	import i2csbc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 150;

	logic clk = 1'b0;
	logic arst_n;

	i2csbc_evt_if bus_evt ();
	i2csbc_cfg_if cfg ();
	i2csbc_rsp_if resp ();

	int fail_count;
	int pending;
	int checked;

	// stimulus bookkeeping
	logic [ADDR_W-1:0] cur_addr;
	logic              cur_enabled;
	logic              rx_filled;
	logic              quiet_stretch;
	int                work_items;
	int                total_items;
	int                reg_writes;
	int                cycle_count;

	i2c_slave_byte_controller_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bus_evt (bus_evt),
		.cfg     (cfg),
		.resp    (resp)
	);

	i2c_slave_byte_controller_top_checker resp_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.bus_evt    (bus_evt),
		.cfg        (cfg),
		.resp       (resp),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// per-word wait, zero during a quiet stretch
	function automatic int draw_wait();
		return quiet_stretch ? 0 : $urandom_range(0, 11);
	endfunction

	// offer one bus word and hold it until taken
	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] sb,
		input logic ab, input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			bus_evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bus_evt.valid         <= 1'b1;
		bus_evt.cmd           <= cmd;
		bus_evt.shift_byte    <= sb;
		bus_evt.start_aborted <= ab;
		bus_evt.entry_index   <= idx;
		bus_evt.entry_value   <= val;
		@(posedge clk);
		while (bus_evt.ready !== 1'b1) @(posedge clk);
		total_items++;
		if (cmd <= CMD_TX_INDEX) work_items++;
	endtask

	task automatic bus_start(input logic ab);
		send_event(CMD_START, BYTE_W'($urandom_range(0, 255)), ab,
			IDX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic bus_shift(input logic [BYTE_W-1:0] b);
		send_event(CMD_SHIFT, b, 1'($urandom_range(0, 1)),
			IDX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic bus_stop();
		send_event(CMD_STOP, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			IDX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic store_write(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		send_event(CMD_TX_WRITE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			idx, val);
	endtask

	task automatic store_index(input logic [IDX_W-1:0] idx);
		send_event(CMD_TX_INDEX, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			idx, BYTE_W'($urandom_range(0, 255)));
	endtask

	// register write, only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (cfg.ready !== 1'b1) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// drain every owed word, then let index and store work finish
	task automatic wait_idle();
		bus_evt.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// response sink with random stalls
	initial begin : resp_sink
		int stall;
		resp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall != 0) begin
				resp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			resp.ready <= 1'b1;
			@(posedge clk);
			while (resp.valid !== 1'b1) @(posedge clk);
		end
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
		$display("i2c_slave_byte_controller_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		int sel;
		int n;
		int m;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [ADDR_W-1:0]    addr;

		arst_n                <= 1'b0;
		bus_evt.valid         <= 1'b0;
		bus_evt.cmd           <= CMD_START;
		bus_evt.shift_byte    <= BYTE_ZERO;
		bus_evt.start_aborted <= 1'b0;
		bus_evt.entry_index   <= '0;
		bus_evt.entry_value   <= BYTE_ZERO;
		cfg.valid             <= 1'b0;
		cfg.index             <= CFG_OWN_ADDRESS;
		cfg.data              <= '0;
		cur_addr      = OWN_ADDRESS_RST;
		cur_enabled   = 1'b1;
		rx_filled     = 1'b0;
		quiet_stretch = 1'b0;
		work_items    = 0;
		total_items   = 0;
		reg_writes    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the whole transmit store so every read is defined
		for (int i = 0; i < TX_DEPTH; i++)
			store_write(IDX_W'(i), (i == 0) ? BYTE_ZERO : (i == 1) ? BYTE_ONES :
				BYTE_W'($urandom_range(0, 255)));
		wait_idle();

		// directed: top address, three-entry transmit window
		write_reg(CFG_OWN_ADDRESS, 7'h7f);
		cur_addr = 7'h7f;
		write_reg(CFG_TX_LENGTH, 7'd3);
		bus_shift(BYTE_ONES);          // not armed yet
		bus_start(1'b1);               // start turned into stop
		bus_start(1'b0);
		bus_stop();                    // stop right after start
		// read through the wrap, ended by NACK
		bus_start(1'b0);
		bus_shift(BYTE_ONES);
		bus_shift(BYTE_ZERO);
		for (int k = 0; k < 4; k++) begin
			bus_shift(BYTE_W'($urandom_range(0, 255)));
			bus_shift((k == 3) ? 8'h01 : BYTE_ZERO);
		end
		// two-byte write delivered at stop
		bus_start(1'b0);
		bus_shift(8'hfe);
		bus_shift(BYTE_W'($urandom_range(0, 255)));
		bus_shift(BYTE_ZERO);
		bus_shift(BYTE_W'($urandom_range(0, 255)));
		bus_shift(BYTE_ONES);
		bus_stop();
		store_index(4'hf);
		for (int c = CMD_TX_INDEX + 1; c < (1 << CMD_W); c++)
			send_event(CMD_W'(c), BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				IDX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
		// address miss, stop then says nothing
		bus_start(1'b0);
		bus_shift(BYTE_ZERO);
		bus_stop();
		wait_idle();

		// disabled: line events ignored, store commands still act
		write_reg(CFG_ENABLED, 7'd0);
		cur_enabled = 1'b0;
		write_reg(CFG_OWN_ADDRESS, 7'h00);
		cur_addr = 7'h00;
		write_reg(CFG_TX_LENGTH, 7'd0);
		bus_start(1'b0);
		bus_shift(BYTE_ZERO);
		bus_stop();
		store_write(4'h0, 8'h5a);
		store_index(4'h9);
		wait_idle();
		write_reg(CFG_ENABLED, 7'd1);
		cur_enabled = 1'b1;
		// enable write drops the armed start
		bus_start(1'b0);
		wait_idle();
		write_reg(CFG_ENABLED, 7'd1);
		bus_shift(BYTE_ZERO);
		bus_stop();
		wait_idle();
		write_reg(CFG_TX_LENGTH, 7'd31);

		// random transactions
		work_items = 0;
		while (work_items < RANDOM_ITEMS) begin
			quiet_stretch = ($urandom_range(0, 3) == 0);
			sel = (!cur_enabled && $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 9);
			case (sel)
				0: begin
					wait_idle();
					reg_sel = cur_enabled ? CFG_IDX_W'($urandom_range(0, 2)) : CFG_ENABLED;
					case (reg_sel)
						CFG_OWN_ADDRESS: begin
							cur_addr = ($urandom_range(0, 3) == 0) ?
								(($urandom_range(0, 1) == 1) ? 7'h7f : 7'h00) :
								ADDR_W'($urandom_range(0, 127));
							write_reg(CFG_OWN_ADDRESS, cur_addr);
						end
						CFG_TX_LENGTH: begin
							write_reg(CFG_TX_LENGTH, ($urandom_range(0, 4) == 0) ?
								(($urandom_range(0, 1) == 1) ? 7'd31 : 7'd0) :
								CFG_DATA_W'($urandom_range(1, 16)));
						end
						default: begin
							cur_enabled = cur_enabled ? ($urandom_range(0, 3) != 0) : 1'b1;
							write_reg(CFG_ENABLED, {6'd0, cur_enabled});
						end
					endcase
				end
				1, 2, 3: begin
					// master write; one long burst overruns the receive store
					n = $urandom_range(0, 6);
					addr = ($urandom_range(0, 7) == 0) ? ADDR_W'($urandom_range(0, 127)) :
						cur_addr;
					if (!rx_filled && cur_enabled && work_items >= 80) begin
						n = RX_DEPTH + 2;
						addr = cur_addr;
						rx_filled = 1'b1;
					end
					bus_start(1'b0);
					bus_shift({addr, 1'b0});
					for (int k = 0; k < n; k++) begin
						bus_shift(BYTE_W'($urandom_range(0, 255)));
						bus_shift(BYTE_W'($urandom_range(0, 255)));
					end
					if (n > RX_DEPTH || $urandom_range(0, 4) != 0) bus_stop();
				end
				4, 5, 6: begin
					// master read, mostly ended by NACK
					m = $urandom_range(1, 6);
					addr = ($urandom_range(0, 7) == 0) ? ADDR_W'($urandom_range(0, 127)) :
						cur_addr;
					bus_start(1'b0);
					bus_shift({addr, 1'b1});
					bus_shift(BYTE_W'($urandom_range(0, 255)));
					for (int k = 0; k < m; k++) begin
						bus_shift(BYTE_W'($urandom_range(0, 255)));
						bus_shift((k == m - 1 && $urandom_range(0, 3) != 0) ?
							BYTE_W'($urandom_range(1, 255)) : BYTE_ZERO);
					end
					if ($urandom_range(0, 4) != 0) bus_stop();
				end
				7: begin
					store_write(IDX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
					store_index(IDX_W'($urandom_range(0, 15)));
				end
				8: begin
					repeat ($urandom_range(1, 3))
						send_event(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)),
							BYTE_W'($urandom_range(0, 255)));
				end
				default: begin
					if ($urandom_range(0, 1) == 1) bus_start(1'b1);
					else bus_stop();
				end
			endcase
		end

		quiet_stretch = 1'b0;
		wait_idle();
		$display("covered %0d bus words, %0d register writes, %0d response words checked",
			total_items, reg_writes, checked);
		$display("receive store overrun %s", rx_filled ? "exercised" : "not reached");
		if (fail_count == 0 && pending == 0) begin
			$display("i2c_slave_byte_controller_top regression: pass");
		end else begin
			$display("i2c_slave_byte_controller_top regression: fail");
		end
		$finish;
	end

endmodule
